// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the circle/line intersection RTL.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CLIP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CLIP_ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`else
`define CLIP_ASSERT(label, prop, msg)
`define CLIP_ASSERT_IMPL(label, pre, post, msg)
`endif
`endif

// File: hw/rtl/clip_pkg.sv
// Types and widths for the circle/line intersection pipeline.
// Depends on nothing.
package clip_pkg;

    localparam int DIFF_W  = 17;
    localparam int CROSS_W = 33;
    localparam int DR2_W   = 34;
    localparam int DISC_W  = 63;
    localparam int RAD_W   = 64;
    localparam int ROOT_W  = 32;
    localparam int REM_W   = 34;
    localparam int NUM_W   = 52;
    localparam int MAG_W   = 51;
    localparam int QUO_W   = 17;
    localparam int LANES   = 4;

    localparam logic [QUO_W-1:0] POS_LIMIT = 17'd32767;
    localparam logic [QUO_W-1:0] NEG_LIMIT = 17'd32768;

    typedef struct packed {
        logic [14:0]        radius;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
    } query_t;

    typedef struct packed {
        logic               hit;
        logic signed [15:0] first_x;
        logic signed [15:0] first_y;
        logic signed [15:0] second_x;
        logic signed [15:0] second_y;
    } result_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0]  dx;
        logic signed [DIFF_W-1:0]  dy;
        logic [DR2_W-1:0]          dr2;
        logic signed [CROSS_W-1:0] cterm;
    } geo_t;

endpackage

// File: hw/rtl/clip_front.sv
// Front pipeline: differences, squared length, cross term and discriminant.
// Depends on clip_pkg and assert_macros.svh.
`include "assert_macros.svh"
module clip_front
    import clip_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              query_valid,
    output logic              query_ready,
    input  query_t            query,
    output logic              disc_valid,
    input  logic              disc_ready,
    output logic [DISC_W-1:0] disc,
    output geo_t              geo
);

    localparam int NS = 6;

    typedef struct packed {
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [31:0]       p1;
        logic signed [31:0]       p2;
        logic [29:0]              r2;
    } s0_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0]  dx;
        logic signed [DIFF_W-1:0]  dy;
        logic signed [CROSS_W-1:0] cterm;
        logic [32:0]               dxx;
        logic [32:0]               dyy;
        logic [29:0]               r2;
    } s1_t;

    typedef struct packed {
        geo_t        geo;
        logic [31:0] cabs;
        logic [29:0] r2;
    } s2_t;

    typedef struct packed {
        geo_t               geo;
        logic [DISC_W-1:0]  dsq;
        logic [61:0]        lo;
        logic [31:0]        hi;
    } s3_t;

    typedef struct packed {
        geo_t              geo;
        logic [DISC_W-1:0] dsq;
        logic [DISC_W-1:0] lhs;
    } s4_t;

    typedef struct packed {
        geo_t              geo;
        logic [DISC_W-1:0] disc;
    } s5_t;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;
    logic [NS:0]   rdy;

    s0_t s0_reg, s0_next;
    s1_t s1_reg, s1_next;
    s2_t s2_reg, s2_next;
    s3_t s3_reg, s3_next;
    s4_t s4_reg, s4_next;
    s5_t s5_reg, s5_next;

    logic signed [33:0] dxx_full;
    logic signed [33:0] dyy_full;
    logic signed [CROSS_W-1:0] cross_neg;
    logic [63:0] lhs_full;
    logic [63:0] diff_full;

    always_comb
    begin
        rdy[NS] = disc_ready;
        for (int i = NS - 1; i >= 0; i--)
        begin
            rdy[i] = ~v_reg[i] | rdy[i+1];
        end
    end

    assign v_next      = (rdy[NS-1:0] & {v_reg[NS-2:0], query_valid}) | (~rdy[NS-1:0] & v_reg);
    assign query_ready = rdy[0];
    assign disc_valid  = v_reg[NS-1];
    assign disc        = s5_reg.disc;
    assign geo         = s5_reg.geo;

    always_comb
    begin
        s0_next.dx = DIFF_W'(query.end_x) - DIFF_W'(query.start_x);
        s0_next.dy = DIFF_W'(query.end_y) - DIFF_W'(query.start_y);
        s0_next.p1 = 32'(query.start_x) * 32'(query.end_y);
        s0_next.p2 = 32'(query.end_x) * 32'(query.start_y);
        s0_next.r2 = 30'(query.radius) * 30'(query.radius);

        dxx_full      = 34'(s0_reg.dx) * 34'(s0_reg.dx);
        dyy_full      = 34'(s0_reg.dy) * 34'(s0_reg.dy);
        s1_next.dx    = s0_reg.dx;
        s1_next.dy    = s0_reg.dy;
        s1_next.cterm = CROSS_W'(s0_reg.p1) - CROSS_W'(s0_reg.p2);
        s1_next.dxx   = dxx_full[32:0];
        s1_next.dyy   = dyy_full[32:0];
        s1_next.r2    = s0_reg.r2;

        cross_neg         = -s1_reg.cterm;
        s2_next.geo.dx    = s1_reg.dx;
        s2_next.geo.dy    = s1_reg.dy;
        s2_next.geo.cterm = s1_reg.cterm;
        s2_next.geo.dr2   = DR2_W'(s1_reg.dxx) + DR2_W'(s1_reg.dyy);
        s2_next.cabs      = s1_reg.cterm[CROSS_W-1] ? cross_neg[31:0] : s1_reg.cterm[31:0];
        s2_next.r2        = s1_reg.r2;

        s3_next.geo = s2_reg.geo;
        s3_next.dsq = DISC_W'(64'(s2_reg.cabs) * 64'(s2_reg.cabs));
        s3_next.lo  = 62'(s2_reg.r2) * 62'(s2_reg.geo.dr2[31:0]);
        s3_next.hi  = 32'(s2_reg.r2) * 32'(s2_reg.geo.dr2[33:32]);

        lhs_full    = 64'(s3_reg.lo) + {s3_reg.hi, 32'd0};
        s4_next.geo = s3_reg.geo;
        s4_next.dsq = s3_reg.dsq;
        s4_next.lhs = lhs_full[DISC_W-1:0];

        diff_full    = {1'b0, s4_reg.lhs} - {1'b0, s4_reg.dsq};
        s5_next.geo  = s4_reg.geo;
        s5_next.disc = (!diff_full[63] && s4_reg.geo.dr2 != '0) ? diff_full[DISC_W-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0]) s0_reg <= s0_next;
        if (rdy[1]) s1_reg <= s1_next;
        if (rdy[2]) s2_reg <= s2_next;
        if (rdy[3]) s3_reg <= s3_next;
        if (rdy[4]) s4_reg <= s4_next;
        if (rdy[5]) s5_reg <= s5_next;
    end

    `CLIP_ASSERT_IMPL(a_disc_needs_length, v_reg[NS-1] && s5_reg.disc != '0, s5_reg.geo.dr2 != '0, "discriminant set for a zero-length line")

endmodule

// File: hw/rtl/clip_sqrt.sv
// Integer square root of the discriminant, one result bit per stage.
// Depends on clip_pkg and assert_macros.svh.
`include "assert_macros.svh"
module clip_sqrt
    import clip_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              disc_valid,
    output logic              disc_ready,
    input  logic [DISC_W-1:0] disc,
    input  geo_t              geo_in,
    output logic              root_valid,
    input  logic              root_ready,
    output logic [ROOT_W-1:0] root,
    output geo_t              geo_out
);

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        geo_t              geo;
    } sq_t;

    logic [ROOT_W-1:0] v_reg;
    logic [ROOT_W-1:0] v_next;
    logic [ROOT_W:0]   rdy;

    sq_t st_reg  [ROOT_W];
    sq_t st_next [ROOT_W];
    sq_t src     [ROOT_W];

    always_comb
    begin
        rdy[ROOT_W] = root_ready;
        for (int i = ROOT_W - 1; i >= 0; i--)
        begin
            rdy[i] = ~v_reg[i] | rdy[i+1];
        end
    end

    assign v_next     = (rdy[ROOT_W-1:0] & {v_reg[ROOT_W-2:0], disc_valid})
                      | (~rdy[ROOT_W-1:0] & v_reg);
    assign disc_ready = rdy[0];
    assign root_valid = v_reg[ROOT_W-1];
    assign root       = st_reg[ROOT_W-1].root;
    assign geo_out    = st_reg[ROOT_W-1].geo;

    always_comb
    begin
        src[0].rad  = RAD_W'(disc);
        src[0].rem  = '0;
        src[0].root = '0;
        src[0].geo  = geo_in;
        for (int i = 1; i < ROOT_W; i++)
        begin
            src[i] = st_reg[i-1];
        end
    end

    for (genvar g = 0; g < ROOT_W; g++)
    begin : g_step
        logic [REM_W+1:0] rem_sh;
        logic [REM_W+1:0] trial;

        always_comb
        begin
            rem_sh             = {src[g].rem, src[g].rad[RAD_W-1:RAD_W-2]};
            trial              = (REM_W + 2)'({src[g].root, 2'b01});
            st_next[g].rad     = src[g].rad << 2;
            st_next[g].geo     = src[g].geo;
            if (rem_sh >= trial)
            begin
                st_next[g].rem  = REM_W'(rem_sh - trial);
                st_next[g].root = {src[g].root[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                st_next[g].rem  = REM_W'(rem_sh);
                st_next[g].root = {src[g].root[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[g])
            begin
                st_reg[g] <= st_next[g];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    `CLIP_ASSERT_IMPL(a_root_remainder, v_reg[ROOT_W-1], (st_reg[ROOT_W-1].rem <= REM_W'({st_reg[ROOT_W-1].root, 1'b0})), "square root remainder exceeds twice the root")

endmodule

// File: hw/rtl/clip_div.sv
// Numerators, four lane dividers by the squared length, and saturation.
// Depends on clip_pkg.
module clip_div
    import clip_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              root_valid,
    output logic              root_ready,
    input  logic [ROOT_W-1:0] root,
    input  geo_t              geo,
    output logic              result_valid,
    input  logic              result_ready,
    output result_t           result
);

    localparam int NDV = QUO_W + 2;
    localparam int NS  = NDV + 3;

    typedef struct packed {
        logic signed [NUM_W-1:0] bx;
        logic signed [NUM_W-1:0] pdx;
        logic signed [NUM_W-1:0] dd;
        logic signed [NUM_W-1:0] ty;
        logic                    neg_dy;
        logic                    hit;
        logic [DR2_W-1:0]        dr2;
    } pp_t;

    typedef struct packed {
        logic [LANES-1:0][NUM_W-1:0] num;
        logic                        hit;
        logic [DR2_W-1:0]            dr2;
    } ss_t;

    typedef struct packed {
        logic                        hit;
        logic [DR2_W-1:0]            dr2;
        logic [LANES-1:0]            neg;
        logic [LANES-1:0]            ovf;
        logic [LANES-1:0][MAG_W-1:0] rem;
        logic [LANES-1:0][QUO_W-1:0] quo;
    } dv_t;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;
    logic [NS:0]   rdy;

    pp_t p_reg, p_next;
    ss_t s_reg, s_next;
    dv_t dv_reg  [NDV];
    dv_t dv_next [NDV];
    result_t res_reg, res_next;

    logic signed [ROOT_W:0]    delta_s;
    logic signed [DIFF_W-1:0]  ady;
    logic signed [NUM_W-1:0]   sum_p;
    logic signed [NUM_W-1:0]   sum_m;
    logic [LANES-1:0][15:0]    lane_out;
    logic [QUO_W-1:0]          neg_q;
    logic [MAG_W-1:0]          neg_n;

    always_comb
    begin
        rdy[NS] = result_ready;
        for (int i = NS - 1; i >= 0; i--)
        begin
            rdy[i] = ~v_reg[i] | rdy[i+1];
        end
    end

    assign v_next       = (rdy[NS-1:0] & {v_reg[NS-2:0], root_valid}) | (~rdy[NS-1:0] & v_reg);
    assign root_ready   = rdy[0];
    assign result_valid = v_reg[NS-1];
    assign result       = res_reg;

    always_comb
    begin
        delta_s       = signed'({1'b0, root});
        ady           = geo.dy[DIFF_W-1] ? -geo.dy : geo.dy;
        p_next.bx     = NUM_W'(geo.cterm) * NUM_W'(geo.dy);
        p_next.pdx    = NUM_W'(geo.dx) * NUM_W'(delta_s);
        p_next.dd     = NUM_W'(geo.cterm) * NUM_W'(geo.dx);
        p_next.ty     = NUM_W'(ady) * NUM_W'(delta_s);
        p_next.neg_dy = geo.dy[DIFF_W-1];
        p_next.hit    = (root != '0);
        p_next.dr2    = geo.dr2;

        sum_p         = p_reg.bx + p_reg.pdx;
        sum_m         = p_reg.bx - p_reg.pdx;
        s_next.num[0] = p_reg.neg_dy ? sum_m : sum_p;
        s_next.num[1] = p_reg.ty - p_reg.dd;
        s_next.num[2] = p_reg.neg_dy ? sum_p : sum_m;
        s_next.num[3] = -p_reg.dd - p_reg.ty;
        s_next.hit    = p_reg.hit;
        s_next.dr2    = p_reg.dr2;

        dv_next[0].hit = s_reg.hit;
        dv_next[0].dr2 = s_reg.dr2;
        dv_next[0].ovf = '0;
        dv_next[0].quo = '0;
        for (int l = 0; l < LANES; l++)
        begin
            neg_n              = MAG_W'(-s_reg.num[l]);
            dv_next[0].neg[l]  = s_reg.num[l][NUM_W-1];
            dv_next[0].rem[l]  = s_reg.num[l][NUM_W-1] ? neg_n : s_reg.num[l][MAG_W-1:0];
        end

        dv_next[1] = dv_reg[0];
        for (int l = 0; l < LANES; l++)
        begin
            dv_next[1].ovf[l] = (dv_reg[0].rem[l] >= {dv_reg[0].dr2, {QUO_W{1'b0}}});
        end
    end

    for (genvar j = 0; j < QUO_W; j++)
    begin : g_bit
        localparam int BIT = QUO_W - 1 - j;
        logic [MAG_W-1:0] sden;

        always_comb
        begin
            sden           = MAG_W'(dv_reg[j+1].dr2) << BIT;
            dv_next[j+2]   = dv_reg[j+1];
            for (int l = 0; l < LANES; l++)
            begin
                if (dv_reg[j+1].rem[l] >= sden)
                begin
                    dv_next[j+2].rem[l] = dv_reg[j+1].rem[l] - sden;
                    dv_next[j+2].quo[l] = {dv_reg[j+1].quo[l][QUO_W-2:0], 1'b1};
                end
                else
                begin
                    dv_next[j+2].quo[l] = {dv_reg[j+1].quo[l][QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            neg_q = -dv_reg[NDV-1].quo[l];
            if (!dv_reg[NDV-1].hit)
            begin
                lane_out[l] = '0;
            end
            else if (dv_reg[NDV-1].neg[l])
            begin
                if (dv_reg[NDV-1].ovf[l] || dv_reg[NDV-1].quo[l] > NEG_LIMIT)
                begin
                    lane_out[l] = NEG_LIMIT[15:0];
                end
                else
                begin
                    lane_out[l] = neg_q[15:0];
                end
            end
            else
            begin
                if (dv_reg[NDV-1].ovf[l] || dv_reg[NDV-1].quo[l] > POS_LIMIT)
                begin
                    lane_out[l] = POS_LIMIT[15:0];
                end
                else
                begin
                    lane_out[l] = dv_reg[NDV-1].quo[l][15:0];
                end
            end
        end
        res_next.hit      = dv_reg[NDV-1].hit;
        res_next.first_x  = signed'(lane_out[0]);
        res_next.first_y  = signed'(lane_out[1]);
        res_next.second_x = signed'(lane_out[2]);
        res_next.second_y = signed'(lane_out[3]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0]) p_reg <= p_next;
        if (rdy[1]) s_reg <= s_next;
        for (int k = 0; k < NDV; k++)
        begin
            if (rdy[k+2]) dv_reg[k] <= dv_next[k];
        end
        if (rdy[NS-1]) res_reg <= res_next;
    end

endmodule

// File: hw/rtl/circle_line_intersection_core.sv
// Circle/line intersection core: front, square root and divider pipelines.
// Depends on clip_pkg, clip_front, clip_sqrt, clip_div and assert_macros.svh.
//
// Use: a query item (radius and two line points, Q8.8) enters on the query
// channel with query_valid/query_ready; one result item (hit flag and two
// intersection points) leaves on the result channel, in query order.
// The pipeline has 60 stages: 6 front stages, 32 square-root stages (one root
// bit each), and 22 divider stages (products, sums, magnitudes, range check,
// 17 quotient bits, saturation).
// Throughput is one item per cycle while the receiver accepts results; the
// 17-stage restoring divider and the 32-stage square root each take a new
// item every cycle unless a stage after them is stalled.
// Every stage holds a valid bit and only advances when the stage after it
// is empty or advancing, so a stalled receiver fills empty stages first and
// query_ready drops only when all 60 stages hold items.
// Reset clears all valid bits; the block is ready for a query as soon as
// reset is released. A stall loses and repeats nothing.
//
`include "assert_macros.svh"
module circle_line_intersection_core
    import clip_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    query_valid,
    output logic    query_ready,
    input  query_t  query,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    logic              disc_valid;
    logic              disc_ready;
    logic [DISC_W-1:0] disc;
    geo_t              geo_front;
    logic              root_valid;
    logic              root_ready;
    logic [ROOT_W-1:0] root;
    geo_t              geo_root;

    clip_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .query_valid (query_valid),
        .query_ready (query_ready),
        .query       (query),
        .disc_valid  (disc_valid),
        .disc_ready  (disc_ready),
        .disc        (disc),
        .geo         (geo_front)
    );

    clip_sqrt u_sqrt (
        .clk        (clk),
        .rst_n      (rst_n),
        .disc_valid (disc_valid),
        .disc_ready (disc_ready),
        .disc       (disc),
        .geo_in     (geo_front),
        .root_valid (root_valid),
        .root_ready (root_ready),
        .root       (root),
        .geo_out    (geo_root)
    );

    clip_div u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .root_valid   (root_valid),
        .root_ready   (root_ready),
        .root         (root),
        .geo          (geo_root),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    `CLIP_ASSERT_IMPL(a_miss_is_zero, result_valid && !result.hit, (result.first_x == '0 && result.first_y == '0 && result.second_x == '0 && result.second_y == '0), "no-hit item carries nonzero points")
    `CLIP_ASSERT_IMPL(a_full_when_blocked, !query_ready, result_valid && !result_ready, "query blocked while the pipeline can advance")
    `CLIP_ASSERT(a_inner_blocked, !root_ready || disc_ready || !disc_valid, "square root stalls its input with an idle divider")

endmodule

// File: tb/circle_line_intersection_core_tb.sv
// Self-checking testbench for circle_line_intersection_core.
// Depends on clip_pkg and the core; predicts results in order, compares each whole.
`timescale 1ns / 1ps
module circle_line_intersection_core_tb;
    import clip_pkg::*;

    localparam int LATENCY = 60;
    localparam int WATCHDOG_LIMIT = 20000;

    logic    clk;
    logic    rst_n;
    logic    query_valid;
    logic    query_ready;
    query_t  query;
    logic    result_valid;
    logic    result_ready;
    result_t result;

    query_t  pending_queries[$];
    result_t expected_points[$];
    int      error_count;
    int      idle_cycles;
    int      gap_left;
    int      stall_left;
    bit      stimulus_done;

    circle_line_intersection_core i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .query_valid(query_valid),
        .query_ready(query_ready),
        .query(query),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic logic [63:0] floor_root(logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
            begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic logic signed [15:0] clamp_quotient(longint num, longint den);
        longint q;
        q = num / den;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[15:0];
    endfunction

    function automatic result_t intersect_points(query_t q);
        result_t res;
        longint sx, sy, ex, ey, dx, dy, dr2, cr, delta, sg, ady, bx, tx, by, ty;
        logic [63:0] lhs, rhs, cabs, r;
        sx = longint'(q.start_x);
        sy = longint'(q.start_y);
        ex = longint'(q.end_x);
        ey = longint'(q.end_y);
        dx = ex - sx;
        dy = ey - sy;
        dr2 = dx * dx + dy * dy;
        cr = sx * ey - ex * sy;
        r = 64'(q.radius);
        lhs = r * r * dr2;
        cabs = (cr < 0) ? -cr : cr;
        rhs = cabs * cabs;
        res = '0;
        if (lhs > rhs && dr2 > 0)
        begin
            delta = floor_root(lhs - rhs);
            if (delta > 0)
            begin
                sg = (dy < 0) ? -1 : 1;
                ady = (dy < 0) ? -dy : dy;
                bx = cr * dy;
                tx = sg * dx * delta;
                by = -(cr * dx);
                ty = ady * delta;
                res.hit = 1'b1;
                res.first_x = clamp_quotient(bx + tx, dr2);
                res.first_y = clamp_quotient(by + ty, dr2);
                res.second_x = clamp_quotient(bx - tx, dr2);
                res.second_y = clamp_quotient(by - ty, dr2);
            end
        end
        return res;
    endfunction

    function automatic int random_gap();
        if ($urandom_range(0, 2) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        return $urandom_range(0, 3);
    endfunction

    function automatic logic signed [15:0] random_coord();
        case ($urandom_range(0, 5))
            0: return 16'($urandom());
            1: return 16'sh7fff;
            2: return -16'sh8000;
            default: return $signed(16'($urandom_range(0, 4096))) - 16'sd2048;
        endcase
    endfunction

    task automatic add_query(int r, int sx, int sy, int ex, int ey);
        query_t q;
        q.radius = r[14:0];
        q.start_x = sx[15:0];
        q.start_y = sy[15:0];
        q.end_x = ex[15:0];
        q.end_y = ey[15:0];
        pending_queries.push_back(q);
    endtask

    initial
    begin
        query_t q;
        int pick;
        add_query(256, -512, 0, 512, 0);
        add_query(256, 0, -512, 0, 512);
        add_query(256, -512, 256, 512, 256);
        add_query(256, -512, 300, 512, 300);
        add_query(256, 100, 100, 100, 100);
        add_query(0, -512, 0, 512, 0);
        add_query(32767, -32768, -32768, 32767, 32767);
        add_query(32767, 32767, -32768, -32768, 32767);
        add_query(32767, -32768, 0, 32767, 1);
        add_query(32767, 0, 0, 1, 0);
        add_query(32767, 0, 0, 0, -1);
        add_query(1, 0, 0, 1, 1);
        add_query(32767, 32767, 32767, 32767, 32767);
        add_query(512, 256, -1000, 300, 1000);
        add_query(512, 256, 1000, 300, -1000);
        add_query(1000, 32767, -32768, 32766, 32767);
        add_query(20000, -3, 5, 7, -2);
        add_query(0, 0, 0, 0, 0);
        for (int i = 0; i < 1250; i++)
        begin
            pick = $urandom_range(0, 3);
            q.radius = (pick == 0) ? 15'($urandom()) : 15'($urandom_range(0, 4096));
            q.start_x = random_coord();
            q.start_y = random_coord();
            q.end_x = random_coord();
            q.end_y = random_coord();
            if (pick == 1 && $urandom_range(0, 9) == 0)
            begin
                q.end_x = q.start_x;
                q.end_y = q.start_y;
            end
            pending_queries.push_back(q);
        end
        stimulus_done = 1'b1;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_valid <= 1'b0;
            query <= '0;
            gap_left <= 0;
        end
        else if (!query_valid || query_ready)
        begin
            if (query_valid) expected_points.push_back(intersect_points(query));
            if (gap_left == 0 && pending_queries.size() > 0)
            begin
                query_valid <= 1'b1;
                query <= pending_queries.pop_front();
                gap_left <= random_gap();
            end
            else
            begin
                query_valid <= 1'b0;
                if (gap_left > 0) gap_left <= gap_left - 1;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            stall_left <= 0;
            error_count <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_points.size() == 0)
                begin
                    $display("%0t: unexpected result item %h", $time, result);
                    error_count <= error_count + 1;
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (result !== want)
                    begin
                        $display("%0t: mismatch expected hit=%0d %0d %0d %0d %0d, actual hit=%0d %0d %0d %0d %0d",
                            $time, want.hit, want.first_x, want.first_y, want.second_x,
                            want.second_y, result.hit, result.first_x, result.first_y,
                            result.second_x, result.second_y);
                        error_count <= error_count + 1;
                    end
                end
            end
            if (stall_left > 0)
            begin
                result_ready <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else
            begin
                result_ready <= 1'b1;
                stall_left <= random_gap();
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((query_valid && query_ready) || (result_valid && result_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
            if (stimulus_done && pending_queries.size() == 0 && !query_valid
                && expected_points.size() == 0)
            begin
                repeat (2 * LATENCY) @(posedge clk);
                if (error_count == 0 && expected_points.size() == 0)
                    $display("RESULT: OK");
                else
                    $display("RESULT: ERROR");
                $finish;
            end
        end
    end

endmodule

// File: circle_line_intersection_core.f
+incdir+hw/rtl
hw/rtl/clip_pkg.sv
hw/rtl/clip_front.sv
hw/rtl/clip_sqrt.sv
hw/rtl/clip_div.sv
hw/rtl/circle_line_intersection_core.sv
tb/circle_line_intersection_core_tb.sv
